FILE: src/erau_pkg.sv
// Shared types and constants for the encoder rotation accelerator.
`default_nettype none

package erau_pkg;

    // Request from the encoder side: one rotation reading or trigger
    typedef struct packed {
        logic [1:0]         mode;
        logic               sensor;
        logic [2:0]         layer;
        logic signed [31:0] rotation_whole;
        logic signed [31:0] rotation_frac;
        logic [31:0]        now_ms;
    } rot_req_t;

    // Result event: a press or a release carrying the scaled move
    typedef struct packed {
        logic               is_press;
        logic signed [15:0] move_x;
        logic signed [15:0] move_y;
        logic [15:0]        wait_ms;
        logic [7:0]         step_count;
        logic               last;
    } evt_req_t;

    // Per encoder and layer state entry
    typedef struct packed {
        logic [1:0]  pend;
        logic [1:0]  prior_dir;
        logic [31:0] last_time;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Direction codes
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_CW   = 2'd1;
    localparam logic [1:0] DIR_CCW  = 2'd2;

    // Request modes
    localparam logic [1:0] MODE_ACCEPT  = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;

    // Curve selection in accel_mode bits 1..0
    localparam logic [1:0] CURVE_LINEAR = 2'd0;
    localparam logic [1:0] CURVE_CUBIC  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_CW_MOVE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CCW_MOVE  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_INT  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_INT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEPS = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEPS = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_HOLD  = 4'd7;

    // Configuration reset values
    localparam logic [15:0] FAST_INT_RST  = 16'd30;
    localparam logic [15:0] SLOW_INT_RST  = 16'd200;
    localparam logic [7:0]  MIN_STEPS_RST = 8'd1;
    localparam logic [7:0]  MAX_STEPS_RST = 8'd5;
    localparam logic [2:0]  ACCEL_RST     = 3'd1;

    // Step limit substitutes for zero settings
    localparam logic [7:0] MIN_STEPS_DFLT = 8'd1;
    localparam logic [7:0] MAX_STEPS_DFLT = 8'd5;

    // Q15 fraction
    localparam int Q15_SHIFT = 15;

    // Serial divider: 31-bit dividend, 16-bit divisor, one bit per cycle
    localparam int DIV_NUM_W = 31;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_CNT_W = 5;

    // Saturation bounds
    localparam logic signed [15:0] MOVE_SAT_LO = 16'sh8000;
    localparam logic signed [15:0] MOVE_SAT_HI = 16'sh7fff;

endpackage

`default_nettype wire

FILE: src/erau_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module erau_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/erau_div.sv
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module erau_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [erau_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [erau_pkg::DIV_DEN_W-1:0] divisor,
    output logic                           done,
    output logic [erau_pkg::DIV_NUM_W-1:0] quotient
);

    import erau_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;

    logic [DIV_DEN_W:0]   shifted;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign shifted = {rem_reg, num_reg[DIV_NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            num_next = {num_reg[DIV_NUM_W-2:0], fits};
            rem_next = fits ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

`default_nettype wire

FILE: src/encoder_rotation_accelerator_unit.sv
// Top level of the encoder rotation accelerator: sequencer, state store and datapath.
//
// Usage:
//   rot channel (rot_valid/rot_ready/rot_req) takes one request per encoder and
//   layer. An accept request records a pending direction; a trigger request with
//   a pending direction produces two results on the evt channel
//   (evt_valid/evt_ready/evt_req): a press, then a release with last set.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the eight
//   settings; it is always ready and should be written only while idle.
// Timing:
//   One request at a time; rot_ready is high only while the sequencer is idle.
//   An in-range request with no result frees the block after the fetch write-back.
//   A trigger whose interval lies at or past a limit passes evaluate, the two
//   move multiplies and then the press; one on the curve adds the serial divider
//   (linear: after one multiply; quadratic: then square, range scale and step;
//   cubic: also a cube step). The multiplies all use one shared multiplier.
// Reset:
//   Configuration returns to its defaults; the state store is swept to zero,
//   one entry a cycle, over all NUM_ENCODERS * NUM_LAYERS entries, with rot_ready low.
// Stall:
//   A stalled receiver holds press or release with its payload steady; the
//   block takes no new request until the release is taken.
`default_nettype none

module encoder_rotation_accelerator_unit #(
    parameter int NUM_ENCODERS = 2,
    parameter int NUM_LAYERS   = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rot_valid,
    output logic                           rot_ready,
    input  erau_pkg::rot_req_t             rot_req,
    output logic                           evt_valid,
    input  logic                           evt_ready,
    output erau_pkg::evt_req_t             evt_req,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [erau_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    import erau_pkg::*;

    localparam int DEPTH  = NUM_ENCODERS * NUM_LAYERS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Sequencer states
    typedef enum logic [13:0] {
        ST_CLEAR   = 14'b00000000000001,
        ST_IDLE    = 14'b00000000000010,
        ST_FETCH   = 14'b00000000000100,
        ST_EVAL    = 14'b00000000001000,
        ST_LIN     = 14'b00000000010000,
        ST_DIV     = 14'b00000000100000,
        ST_SQ      = 14'b00000001000000,
        ST_CUBE    = 14'b00000010000000,
        ST_RNG     = 14'b00000100000000,
        ST_STEP    = 14'b00001000000000,
        ST_MX      = 14'b00010000000000,
        ST_MY      = 14'b00100000000000,
        ST_PRESS   = 14'b01000000000000,
        ST_RELEASE = 14'b10000000000000
    } state_t;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [31:0] cw_move_reg;
    logic [31:0] ccw_move_reg;
    logic [15:0] fast_int_reg;
    logic [15:0] slow_int_reg;
    logic [7:0]  min_steps_reg;
    logic [7:0]  max_steps_reg;
    logic [2:0]  accel_reg;
    logic [15:0] tap_hold_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_move_reg   <= '0;
            ccw_move_reg  <= '0;
            fast_int_reg  <= FAST_INT_RST;
            slow_int_reg  <= SLOW_INT_RST;
            min_steps_reg <= MIN_STEPS_RST;
            max_steps_reg <= MAX_STEPS_RST;
            accel_reg     <= ACCEL_RST;
            tap_hold_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CW_MOVE:   cw_move_reg   <= cfg_data;
                REG_CCW_MOVE:  ccw_move_reg  <= cfg_data;
                REG_FAST_INT:  fast_int_reg  <= cfg_data[15:0];
                REG_SLOW_INT:  slow_int_reg  <= cfg_data[15:0];
                REG_MIN_STEPS: min_steps_reg <= cfg_data[7:0];
                REG_MAX_STEPS: max_steps_reg <= cfg_data[7:0];
                REG_ACCEL:     accel_reg     <= cfg_data[2:0];
                REG_TAP_HOLD:  tap_hold_reg  <= cfg_data[15:0];
                default:       ;  // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    state_t             state_reg, state_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;

    rot_req_t           item_reg, item_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [1:0]         dir_reg, dir_next;
    logic [31:0]        dt_reg, dt_next;
    logic [15:0]        dist_reg, dist_next;
    logic [15:0]        span_reg, span_next;
    logic [7:0]         range_reg, range_next;
    logic [7:0]         lo_s_reg, lo_s_next;
    logic [14:0]        tq_reg, tq_next;
    logic [29:0]        prod_reg, prod_next;
    logic [7:0]         steps_reg, steps_next;
    logic signed [15:0] mx_reg, mx_next;
    logic signed [15:0] my_reg, my_next;

    // ---------------------------------------------------------------
    // State store
    // ---------------------------------------------------------------
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    entry_t             ram_wdata;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             entry;

    erau_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry = entry_t'(ram_rdata);

    // Entry address and range check of the incoming request
    logic              rot_in_range;
    logic [ADDR_W-1:0] rot_addr;

    assign rot_in_range = (32'(rot_req.sensor) < NUM_ENCODERS)
                       && (32'(rot_req.layer) < NUM_LAYERS);
    assign rot_addr     = ADDR_W'(32'(rot_req.sensor) * NUM_LAYERS + 32'(rot_req.layer));
    assign ram_raddr    = rot_addr;

    // ---------------------------------------------------------------
    // Direction and interval of a fetched entry
    // ---------------------------------------------------------------
    logic [31:0] rot_dir_word;
    logic [1:0]  new_pend;
    logic        reversal;
    logic [31:0] dt_c;

    assign rot_dir_word = (item_reg.rotation_whole != 32'sd0) ? item_reg.rotation_whole
                                                               : item_reg.rotation_frac;
    assign new_pend     = (rot_dir_word == 32'd0) ? DIR_NONE
                        : (rot_dir_word[31] ? DIR_CCW : DIR_CW);

    // reversal counts as slow only when a prior event with another direction exists
    assign reversal = accel_reg[2] && (entry.last_time != 32'd0)
                   && (entry.prior_dir != DIR_NONE) && (entry.prior_dir != entry.pend);
    assign dt_c     = ((entry.last_time == 32'd0) || reversal)
                    ? {16'd0, slow_int_reg}
                    : item_reg.now_ms - entry.last_time;

    // ---------------------------------------------------------------
    // Curve limits from configuration
    // ---------------------------------------------------------------
    logic [15:0] lo_t;
    logic [16:0] hi_t;
    logic [7:0]  min_s, max_s, lo_s_c, hi_s_c, range_c;
    logic [16:0] span_w, dist_w;
    logic [1:0]  curve;

    assign curve  = accel_reg[1:0];
    assign lo_t   = (fast_int_reg == 16'd0) ? 16'd1 : fast_int_reg;
    assign hi_t   = (slow_int_reg <= lo_t) ? ({1'b0, lo_t} + 17'd1) : {1'b0, slow_int_reg};
    assign min_s  = (min_steps_reg == 8'd0) ? MIN_STEPS_DFLT : min_steps_reg;
    assign max_s  = (max_steps_reg == 8'd0) ? MAX_STEPS_DFLT : max_steps_reg;
    assign lo_s_c = (max_s < min_s) ? max_s : min_s;
    assign hi_s_c = (max_s < min_s) ? min_s : max_s;
    assign range_c = hi_s_c - lo_s_c;
    assign span_w = hi_t - {1'b0, lo_t};
    assign dist_w = hi_t - dt_reg[16:0];

    // ---------------------------------------------------------------
    // Shared multiplier
    // ---------------------------------------------------------------
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    logic signed [15:0] sat_c;
    logic [31:0]        mv_sel;

    assign mv_sel = (dir_reg == DIR_CW) ? cw_move_reg : ccw_move_reg;

    always_comb
    begin
        unique case (state_reg)
            ST_LIN:
            begin
                mul_a = {1'b0, dist_reg};
                mul_b = {9'd0, range_reg};
            end
            ST_SQ:
            begin
                mul_a = {2'd0, tq_reg};
                mul_b = {2'd0, tq_reg};
            end
            ST_CUBE:
            begin
                mul_a = {2'd0, prod_reg[29:Q15_SHIFT]};
                mul_b = {2'd0, tq_reg};
            end
            ST_RNG:
            begin
                mul_a = {9'd0, range_reg};
                mul_b = {2'd0, prod_reg[29:Q15_SHIFT]};
            end
            ST_MX:
            begin
                mul_a = {mv_sel[15], mv_sel[15:0]};
                mul_b = {9'd0, steps_reg};
            end
            ST_MY:
            begin
                mul_a = {mv_sel[31], mv_sel[31:16]};
                mul_b = {9'd0, steps_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign sat_c = (mul_p < 34'(MOVE_SAT_LO)) ? MOVE_SAT_LO
                 : (mul_p > 34'(MOVE_SAT_HI)) ? MOVE_SAT_HI
                 : mul_p[15:0];

    // ---------------------------------------------------------------
    // Serial divider
    // ---------------------------------------------------------------
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_dividend;
    logic [DIV_DEN_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    erau_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        item_next    = item_reg;
        addr_next    = addr_reg;
        dir_next     = dir_reg;
        dt_next      = dt_reg;
        dist_next    = dist_reg;
        span_next    = span_reg;
        range_next   = range_reg;
        lo_s_next    = lo_s_reg;
        tq_next      = tq_reg;
        prod_next    = prod_reg;
        steps_next   = steps_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;

        ram_we       = 1'b0;
        ram_waddr    = addr_reg;
        ram_wdata    = entry;
        div_start    = 1'b0;
        div_dividend = {dist_w[15:0], 15'd0};
        div_divisor  = span_w[15:0];

        unique case (state_reg)
            ST_CLEAR:
            begin
                // sweep the store to zero after reset
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (rot_valid)
                begin
                    item_next = rot_req;
                    addr_next = rot_addr;
                    if (rot_in_range)
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH:
            begin
                // entry arrived from the store: update and write back
                ram_we = 1'b1;
                if (item_reg.mode == MODE_ACCEPT)
                begin
                    ram_wdata.pend = new_pend;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    ram_wdata.pend = DIR_NONE;
                    if ((item_reg.mode == MODE_TRIGGER) && (entry.pend != DIR_NONE))
                    begin
                        ram_wdata.last_time = item_reg.now_ms;
                        ram_wdata.prior_dir = entry.pend;
                        dir_next            = entry.pend;
                        dt_next             = dt_c;
                        state_next          = ST_EVAL;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EVAL:
            begin
                range_next = range_c;
                lo_s_next  = lo_s_c;
                dist_next  = dist_w[15:0];
                span_next  = span_w[15:0];
                if (dt_reg <= {16'd0, lo_t})
                begin
                    steps_next = hi_s_c;
                    state_next = ST_MX;
                end
                else if (dt_reg >= {15'd0, hi_t})
                begin
                    steps_next = lo_s_c;
                    state_next = ST_MX;
                end
                else if (curve == CURVE_LINEAR)
                begin
                    state_next = ST_LIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_LIN:
            begin
                div_start    = 1'b1;
                div_dividend = mul_p[DIV_NUM_W-1:0];
                div_divisor  = span_reg;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (curve == CURVE_LINEAR)
                    begin
                        steps_next = lo_s_reg + div_quot[7:0];
                        state_next = ST_MX;
                    end
                    else
                    begin
                        tq_next    = div_quot[14:0];
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ:
            begin
                prod_next  = mul_p[29:0];
                state_next = (curve == CURVE_CUBIC) ? ST_CUBE : ST_RNG;
            end
            ST_CUBE:
            begin
                prod_next  = mul_p[29:0];
                state_next = ST_RNG;
            end
            ST_RNG:
            begin
                prod_next  = mul_p[29:0];
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                steps_next = lo_s_reg + prod_reg[22:Q15_SHIFT];
                state_next = ST_MX;
            end
            ST_MX:
            begin
                mx_next    = sat_c;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                my_next    = sat_c;
                state_next = ST_PRESS;
            end
            ST_PRESS:
            begin
                if (evt_ready)
                begin
                    state_next = ST_RELEASE;
                end
            end
            ST_RELEASE:
            begin
                if (evt_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        addr_reg  <= addr_next;
        dir_reg   <= dir_next;
        dt_reg    <= dt_next;
        dist_reg  <= dist_next;
        span_reg  <= span_next;
        range_reg <= range_next;
        lo_s_reg  <= lo_s_next;
        tq_reg    <= tq_next;
        prod_reg  <= prod_next;
        steps_reg <= steps_next;
        mx_reg    <= mx_next;
        my_reg    <= my_next;
    end

    // ---------------------------------------------------------------
    // Handshakes and result payload
    // ---------------------------------------------------------------
    assign rot_ready = (state_reg == ST_IDLE);
    assign evt_valid = (state_reg == ST_PRESS) || (state_reg == ST_RELEASE);

    always_comb
    begin
        evt_req.is_press   = (state_reg == ST_PRESS);
        evt_req.move_x     = mx_reg;
        evt_req.move_y     = my_reg;
        evt_req.wait_ms    = (state_reg == ST_PRESS) ? tap_hold_reg : 16'd0;
        evt_req.step_count = steps_reg;
        evt_req.last       = (state_reg == ST_RELEASE);
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // no new request while a result is on offer
    a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid |-> !rot_ready)
        else $error("request port ready while a result is pending");

    // a taken press is followed at once by its release
    a_release_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (evt_valid && evt_ready && evt_req.is_press) |=> (evt_valid && evt_req.last))
        else $error("press not followed by release");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside of divide state");

endmodule

`default_nettype wire
